// File: design/frm_pkg.sv
// shared types and constants of the feedback rate meter
package frm_pkg;

	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int WLEN_W   = 16;
	localparam int LOAD_W   = 8;
	localparam int RATE_W   = 8;
	localparam int LOAD_N   = 6;
	localparam int SCALE_W  = 10;
	localparam int DVD_W    = COUNT_W + SCALE_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000);
	localparam logic [RATE_W-1:0]  RATE_MAX   = RATE_W'(255);
	localparam logic [WLEN_W-1:0]  WLEN_RST   = WLEN_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FEEDBACK_EN = 1'b0,
		CFG_WINDOW_LEN  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              got_feedback;
		logic [LOAD_W-1:0] load_a;
		logic [LOAD_W-1:0] load_b;
		logic [LOAD_W-1:0] load_c;
		logic [LOAD_W-1:0] load_d;
		logic [LOAD_W-1:0] load_e;
		logic [LOAD_W-1:0] load_f;
	} in_item_t;

	typedef struct packed {
		logic [RATE_W-1:0]  rate_average;
		logic               rate_sampled;
		logic [COUNT_W-1:0] polls_in_window;
		logic [LOAD_W-1:0]  held_load_a;
		logic [LOAD_W-1:0]  held_load_b;
		logic [LOAD_W-1:0]  held_load_c;
		logic [LOAD_W-1:0]  held_load_d;
		logic [LOAD_W-1:0]  held_load_e;
		logic [LOAD_W-1:0]  held_load_f;
	} out_item_t;

	typedef struct packed {
		logic [LOAD_W-1:0] a;
		logic [LOAD_W-1:0] b;
		logic [LOAD_W-1:0] c;
		logic [LOAD_W-1:0] d;
		logic [LOAD_W-1:0] e;
		logic [LOAD_W-1:0] f;
	} loads_t;

endpackage

// File: design/frm_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module frm_div #(
	parameter int DVD_W = frm_pkg::DVD_W,
	parameter int DVS_W = frm_pkg::TIME_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             fits;

	// a zero divisor always fits, so the quotient comes out all ones
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/feedback_rate_meter_ewma.sv
// top level of the windowed feedback rate meter with smoothed rate
// sequence: a request with no closing window goes through the done state into the output
//   register; a closing window first passes the load state, 26 divider steps and the average update
//   requests are taken one at a time, only in the idle state, via a divider that serves only this block;
//   a request is taken while the previous result still waits in the output register
// reset: arst_n clears window, count, average, held loads and enable; window length 1000
module feedback_rate_meter_ewma (
	input  logic                                clk,
	input  logic                                arst_n,
	// poll requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  frm_pkg::in_item_t                   in_data,
	// results
	output logic                                out_valid,
	input  logic                                out_stall,
	output frm_pkg::out_item_t                  out_data,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  frm_pkg::cfg_idx_t                   cfg_index,
	input  logic [frm_pkg::WLEN_W-1:0]          cfg_data
);

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                          state_q;

	// configuration
	logic                            fb_en_q;
	logic [frm_pkg::WLEN_W-1:0]      wlen_q;

	// meter state
	frm_pkg::loads_t                 loads_q;
	logic [frm_pkg::TIME_W-1:0]      wstart_q;
	logic [frm_pkg::COUNT_W-1:0]     count_q;
	logic [frm_pkg::RATE_W-1:0]      avg_q;

	// per-request working registers
	logic [frm_pkg::TIME_W-1:0]      now_q;
	logic [frm_pkg::TIME_W-1:0]      elapsed_q;
	logic                            sampled_q;

	// output register
	logic                            out_valid_q;
	frm_pkg::out_item_t              out_q;

	// request decode
	logic                            in_acc;
	logic                            update;
	logic [frm_pkg::TIME_W-1:0]      start_eff;
	logic [frm_pkg::TIME_W-1:0]      elapsed;
	logic [frm_pkg::COUNT_W-1:0]     count_inc;
	logic                            close_win;

	// divider hookup
	logic                            div_start;
	logic [frm_pkg::DVD_W-1:0]       div_dvd;
	logic                            div_done;
	logic [frm_pkg::DVD_W-1:0]       div_quo;

	// rate and average update
	logic [frm_pkg::RATE_W-1:0]      rate;
	logic [frm_pkg::RATE_W+1:0]      blend;
	logic [frm_pkg::RATE_W-1:0]      avg_next;

	logic                            out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// a zero start means the window has not opened yet, so this poll opens it
	assign update    = fb_en_q && in_data.got_feedback;
	assign start_eff = (wstart_q == '0) ? in_data.now_ms : wstart_q;
	assign elapsed   = in_data.now_ms - start_eff;
	assign count_inc = count_q + frm_pkg::COUNT_W'(1);
	assign close_win = elapsed >= frm_pkg::TIME_W'(wlen_q);

	// dividend is count*1000, at most 26 bits; registered inside the divider
	assign div_start = (state_q == ST_LOAD);
	assign div_dvd   = frm_pkg::DVD_W'(count_q) * frm_pkg::DVD_W'(frm_pkg::RATE_SCALE);

	frm_div #(
		.DVD_W (frm_pkg::DVD_W),
		.DVS_W (frm_pkg::TIME_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// saturate the rate; zero elapsed time gives an all-ones quotient and so 255
	assign rate = (div_quo > frm_pkg::DVD_W'(frm_pkg::RATE_MAX)) ?
		frm_pkg::RATE_MAX : div_quo[frm_pkg::RATE_W-1:0];

	// average of three parts old and one part new, seeded when empty
	assign blend    = ((frm_pkg::RATE_W+2)'(avg_q) * (frm_pkg::RATE_W+2)'(3))
		+ (frm_pkg::RATE_W+2)'(rate);
	assign avg_next = (avg_q == '0) ? rate : blend[frm_pkg::RATE_W+1:2];

	// output slot can take a result when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_en_q <= 1'b0;
			wlen_q  <= frm_pkg::WLEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				frm_pkg::CFG_FEEDBACK_EN: fb_en_q <= cfg_data[0];
				frm_pkg::CFG_WINDOW_LEN:  wlen_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loads_q     <= '0;
			wstart_q    <= '0;
			count_q     <= '0;
			avg_q       <= '0;
			sampled_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sampled_q <= 1'b0;
						// a closing window goes through the divider first
						state_q   <= (update && close_win) ? ST_LOAD : ST_DONE;
						if (update) begin
							loads_q  <= '{in_data.load_a, in_data.load_b,
								in_data.load_c, in_data.load_d,
								in_data.load_e, in_data.load_f};
							wstart_q <= start_eff;
							count_q  <= count_inc;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q     <= avg_next;
						wstart_q  <= now_q;
						count_q   <= '0;
						sampled_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid: set when a result is loaded, cleared once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// request payload kept for the division and window restart
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q     <= in_data.now_ms;
			elapsed_q <= elapsed;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.rate_average    <= avg_q;
			out_q.rate_sampled    <= sampled_q;
			out_q.polls_in_window <= count_q;
			out_q.held_load_a     <= loads_q.a;
			out_q.held_load_b     <= loads_q.b;
			out_q.held_load_c     <= loads_q.c;
			out_q.held_load_d     <= loads_q.d;
			out_q.held_load_e     <= loads_q.e;
			out_q.held_load_f     <= loads_q.f;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: design/frm_checker.sv
// port-level checks of the feedback rate meter, bound to the top level
module frm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  frm_pkg::out_item_t out_data
);

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a closed window always restarts with an empty count
	a_sample_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rate_sampled |-> out_data.polls_in_window == '0)
		else $error("sampled result with nonzero poll count");

	// one request at a time: busy right after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken back to back");

	// a new result appears only out of the busy phase
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in flight");

endmodule

bind feedback_rate_meter_ewma frm_checker u_frm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
